[rtl/core/ecfb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the escaped CRC-16 frame builder.
// Depends on nothing; the front, queue, back and top-level files and the bench import it.
package ecfb_pkg;

   // Frame layout.
   localparam int PREAMBLE_BYTES = 8;
   localparam int PRE_CNT_W      = $clog2(PREAMBLE_BYTES + 1);
   localparam int BODY_BYTES     = 19;
   localparam int BODY_IDX_W     = 5;

   localparam logic [7:0]  PREAMBLE_VALUE = 8'hA5;
   localparam logic [7:0]  END_VALUE      = 8'h5A;
   localparam logic [15:0] FRAME_LEN_BASE = 16'd5;

   // Escape codes of the wire format and the CRC-16/ARC polynomial.
   localparam logic [7:0]  ESC_LEAD_A = 8'hA6;
   localparam logic [7:0]  ESC_LEAD_B = 8'h5B;
   localparam logic [7:0]  ESC_ONE    = 8'h01;
   localparam logic [7:0]  ESC_TWO    = 8'h02;
   localparam logic [15:0] ARC_POLY   = 16'hA001;

   // Register indexes.
   localparam logic [7:0] CSR_DST_ADDRESS      = 8'd0;
   localparam logic [7:0] CSR_SRC_ADDRESS      = 8'd1;
   localparam logic [7:0] CSR_DEVICE_TYPE      = 8'd2;
   localparam logic [7:0] CSR_PROTOCOL_VERSION = 8'd3;

   // Request kinds.
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One unit of work for the back end: a frame opening or one payload byte.
   typedef struct packed {
      logic        is_start;
      logic        last;
      logic [7:0]  command_group;
      logic [7:0]  command_code;
      logic [7:0]  response_flag;
      logic [7:0]  option_first;
      logic [7:0]  option_second;
      logic [15:0] frame_len;
      logic [7:0]  payload_byte;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Header fields held in configuration registers.
   typedef struct packed {
      logic [15:0] dst_address;
      logic [15:0] src_address;
      logic [7:0]  device_type;
      logic [7:0]  protocol_version;
   } header_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREAMBLE,
      ST_BODY,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_END
   } back_state_type;

endpackage

[rtl/core/ecfb_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the frame builder: request, response and register write.
// Stand-alone; widths follow the request and result fields of the block.
interface ecfb_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  command_group;
   logic [7:0]  command_code;
   logic [7:0]  response_flag;
   logic [7:0]  option_first;
   logic [7:0]  option_second;
   logic [15:0] payload_length;
   logic [7:0]  payload_byte;

   modport source (output valid, kind, command_group, command_code, response_flag,
                   option_first, option_second, payload_length, payload_byte,
                   input ready);
   modport sink   (input valid, kind, command_group, command_code, response_flag,
                   option_first, option_second, payload_length, payload_byte,
                   output ready);
endinterface

interface ecfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_done;

   modport source (output valid, out_byte, frame_done, input ready);
   modport sink   (input valid, out_byte, frame_done, output ready);
endinterface

interface ecfb_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ecfb_front.sv]
`timescale 1ns / 1ps
// Front end: takes requests and register writes, tracks the open frame and
// queues jobs for the back end. Depends on ecfb_pkg and ecfb_if.
module ecfb_front
   import ecfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   ecfb_req_if.sink         req_bus,
   ecfb_csr_if.sink         csr_bus,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job,
   output header_cfg_type   header_cfg
);

   header_cfg_type cfg_ff, cfg_in;
   logic           open_ff, open_in;
   logic [15:0]    remain_ff, remain_in;
   logic           accept, start_ok, payload_ok;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_DST_ADDRESS:      cfg_in.dst_address      = csr_bus.data;
            CSR_SRC_ADDRESS:      cfg_in.src_address      = csr_bus.data;
            CSR_DEVICE_TYPE:      cfg_in.device_type      = csr_bus.data[7:0];
            CSR_PROTOCOL_VERSION: cfg_in.protocol_version = csr_bus.data[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   assign header_cfg = cfg_ff;

   // A request is taken whenever the queue has room; out-of-order ones are dropped.
   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign start_ok      = accept && (req_bus.kind == KIND_START) && !open_ff;
   assign payload_ok    = accept && (req_bus.kind == KIND_PAYLOAD) && open_ff;
   assign push          = start_ok || payload_ok;

   // Build the job for the back end.
   always_comb begin
      push_job.is_start      = start_ok;
      push_job.last          = start_ok ? (req_bus.payload_length == 16'd0)
                                        : (remain_ff == 16'd1);
      push_job.command_group = req_bus.command_group;
      push_job.command_code  = req_bus.command_code;
      push_job.response_flag = req_bus.response_flag;
      push_job.option_first  = req_bus.option_first;
      push_job.option_second = req_bus.option_second;
      push_job.frame_len     = req_bus.payload_length + FRAME_LEN_BASE;
      push_job.payload_byte  = req_bus.payload_byte;
   end

   // Frame tracking: the frame closes with its last payload byte.
   always_comb begin
      open_in   = open_ff;
      remain_in = remain_ff;
      if (start_ok) begin
         open_in   = (req_bus.payload_length != 16'd0);
         remain_in = req_bus.payload_length;
      end else if (payload_ok) begin
         open_in   = (remain_ff != 16'd1);
         remain_in = remain_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff                 <= 1'b0;
         remain_ff               <= 16'd0;
         cfg_ff.dst_address      <= 16'd1;
         cfg_ff.src_address      <= 16'h8000;
         cfg_ff.device_type      <= 8'hFE;
         cfg_ff.protocol_version <= 8'd2;
      end else begin
         open_ff   <= open_in;
         remain_ff <= remain_in;
         cfg_ff    <= cfg_in;
      end
   end

   // An open frame always expects at least one more payload byte.
   assert property (@(posedge clock) disable iff (reset) open_ff |-> (remain_ff != 16'd0))
      else $error("open frame with no payload left");

   // Nothing is queued when the queue is full.
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("job pushed into a full queue");

endmodule

[rtl/core/ecfb_queue.sv]
`timescale 1ns / 1ps
// Short job queue between the front and back ends of the frame builder.
// Depends on ecfb_pkg.
module ecfb_queue
   import ecfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign status.empty = (count_ff == QCNT_W'(0));
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // Job storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // The back end only takes a job that is there.
   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("pop from an empty queue");

endmodule

[rtl/core/ecfb_back.sv]
`timescale 1ns / 1ps
// Back end: sequences preamble, header, command, payload, CRC and end marker,
// escapes body bytes and drives the response register. Depends on ecfb_pkg, ecfb_if.
module ecfb_back
   import ecfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type q_status,
   input  header_cfg_type   header_cfg,
   output logic             pop,
   ecfb_rsp_if.source       rsp_bus
);

   // One byte of CRC-16/ARC, reflected polynomial, eight shift steps.
   function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ ARC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == PREAMBLE_VALUE) || (b == ESC_LEAD_A) || (b == END_VALUE) ||
             (b == ESC_LEAD_B);
   endfunction

   function automatic logic [7:0] escape_first(input logic [7:0] b);
      return ((b == PREAMBLE_VALUE) || (b == ESC_LEAD_A)) ? ESC_LEAD_A : ESC_LEAD_B;
   endfunction

   function automatic logic [7:0] escape_second(input logic [7:0] b);
      return ((b == PREAMBLE_VALUE) || (b == END_VALUE)) ? ESC_TWO : ESC_ONE;
   endfunction

   back_state_type        state_ff, state_in;
   job_type               cur_ff, cur_in;
   logic [15:0]           crc_ff, crc_in;
   logic [PRE_CNT_W-1:0]  pre_cnt_ff, pre_cnt_in;
   logic [BODY_IDX_W-1:0] body_idx_ff, body_idx_in;
   logic                  pending_ff, pending_in;
   logic [7:0]            second_ff, second_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_end_ff, rsp_end_in;

   logic                  advance;
   logic                  emit_valid, emit_raw, emit_end, feed_crc;
   logic [7:0]            emit_byte, body_byte;

   // Header and command bytes of the current frame, in wire order.
   always_comb begin
      case (body_idx_ff) inside
         5'd0:          body_byte = header_cfg.dst_address[7:0];
         5'd1:          body_byte = header_cfg.dst_address[15:8];
         5'd2:          body_byte = header_cfg.src_address[7:0];
         5'd3:          body_byte = header_cfg.src_address[15:8];
         [5'd4:5'd9]:   body_byte = 8'h00;
         5'd10:         body_byte = header_cfg.device_type;
         5'd11:         body_byte = header_cfg.protocol_version;
         5'd12:         body_byte = cur_ff.frame_len[7:0];
         5'd13:         body_byte = cur_ff.frame_len[15:8];
         5'd14:         body_byte = cur_ff.command_group;
         5'd15:         body_byte = cur_ff.command_code;
         5'd16:         body_byte = cur_ff.response_flag;
         5'd17:         body_byte = cur_ff.option_first;
         5'd18:         body_byte = cur_ff.option_second;
         default:       body_byte = 8'h00;
      endcase
   end

   // The output register moves on when empty or when its byte is taken.
   assign advance = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer: next state, byte choice and CRC update.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      crc_in       = crc_ff;
      pre_cnt_in   = pre_cnt_ff;
      body_idx_in  = body_idx_ff;
      pending_in   = pending_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      pop          = 1'b0;
      emit_valid   = 1'b0;
      emit_raw     = 1'b0;
      emit_end     = 1'b0;
      feed_crc     = 1'b0;
      emit_byte    = 8'h00;

      if (advance) begin
         if (pending_ff) begin
            // Second byte of an escape pair.
            emit_valid = 1'b1;
            emit_raw   = 1'b1;
            emit_byte  = second_ff;
            pending_in = 1'b0;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (!q_status.empty) begin
                     pop        = 1'b1;
                     cur_in     = head;
                     emit_valid = 1'b1;
                     if (head.is_start) begin
                        emit_raw    = 1'b1;
                        emit_byte   = PREAMBLE_VALUE;
                        crc_in      = 16'h0000;
                        pre_cnt_in  = PRE_CNT_W'(1);
                        body_idx_in = '0;
                        state_in    = (PREAMBLE_BYTES == 1) ? ST_BODY : ST_PREAMBLE;
                     end else begin
                        emit_byte = head.payload_byte;
                        feed_crc  = 1'b1;
                        state_in  = head.last ? ST_CRC_LO : ST_IDLE;
                     end
                  end
               end
               ST_PREAMBLE: begin
                  emit_valid = 1'b1;
                  emit_raw   = 1'b1;
                  emit_byte  = PREAMBLE_VALUE;
                  pre_cnt_in = pre_cnt_ff + PRE_CNT_W'(1);
                  if (pre_cnt_ff == PRE_CNT_W'(PREAMBLE_BYTES - 1)) begin
                     state_in = ST_BODY;
                  end
               end
               ST_BODY: begin
                  emit_valid  = 1'b1;
                  emit_byte   = body_byte;
                  feed_crc    = 1'b1;
                  body_idx_in = body_idx_ff + BODY_IDX_W'(1);
                  if (body_idx_ff == BODY_IDX_W'(BODY_BYTES - 1)) begin
                     state_in = cur_ff.last ? ST_CRC_LO : ST_IDLE;
                  end
               end
               ST_CRC_LO: begin
                  emit_valid = 1'b1;
                  emit_byte  = crc_ff[7:0];
                  state_in   = ST_CRC_HI;
               end
               ST_CRC_HI: begin
                  emit_valid = 1'b1;
                  emit_byte  = crc_ff[15:8];
                  state_in   = ST_END;
               end
               ST_END: begin
                  emit_valid = 1'b1;
                  emit_raw   = 1'b1;
                  emit_end   = 1'b1;
                  emit_byte  = END_VALUE;
                  crc_in     = 16'h0000;
                  state_in   = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // Load the response register, splitting escaped bytes into two.
         if (emit_valid) begin
            rsp_valid_in = 1'b1;
            rsp_end_in   = emit_end;
            if (!emit_raw && needs_escape(emit_byte)) begin
               rsp_byte_in = escape_first(emit_byte);
               pending_in  = 1'b1;
               second_in   = escape_second(emit_byte);
            end else begin
               rsp_byte_in = emit_byte;
            end
         end
         if (feed_crc) begin
            crc_in = crc_arc_byte(crc_ff, emit_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         crc_ff       <= 16'h0000;
         pre_cnt_ff   <= '0;
         body_idx_ff  <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         pre_cnt_ff   <= pre_cnt_in;
         body_idx_ff  <= body_idx_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      second_ff   <= second_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_byte   = rsp_byte_ff;
   assign rsp_bus.frame_done = rsp_end_ff;

   // A pending escape byte always follows a first byte still on the port.
   assert property (@(posedge clock) disable iff (reset) pending_ff |-> rsp_valid_ff)
      else $error("escape byte pending without a shown first byte");

   // The end flag only marks the end marker.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_end_ff) |-> (rsp_byte_ff == END_VALUE))
      else $error("frame end flag on a byte other than the end marker");

endmodule

[rtl/core/escaped_crc16_frame_builder.sv]
`timescale 1ns / 1ps
// Top level of the escaped CRC-16 frame builder: front end, job queue, back end.
// Depends on ecfb_pkg, ecfb_if, ecfb_front, ecfb_queue and ecfb_back.
//
// The block turns start and payload requests into a byte-stuffed wire stream
// with a CRC-16/ARC check, one wire byte per cycle on the response channel
// while the receiver is ready. A start request gives 8 preamble bytes and 19
// header and command bytes, each body byte going out as two wire bytes when it
// is escaped; a payload request gives one or two bytes, and the last one of a
// frame adds two to four CRC bytes and the end marker. The output rate is set
// by the back-end byte sequencer; requests are taken one per cycle while the
// four-entry job queue has room. Requests out of order (payload with no open
// frame, start while one is open) are taken and dropped.
// Register writes are always taken and must be made while no frame is in flight.
module escaped_crc16_frame_builder
   import ecfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ecfb_req_if.sink     req_bus,
   ecfb_rsp_if.source   rsp_bus,
   ecfb_csr_if.sink     csr_bus
);

   queue_status_type q_status;
   header_cfg_type   header_cfg;
   job_type          push_job, head;
   logic             push, pop;

   // Front end: request decode and frame tracking.
   ecfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job),
      .header_cfg (header_cfg)
   );

   // Job queue.
   ecfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // Back end: byte sequencer, escaping and CRC.
   ecfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .header_cfg (header_cfg),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the escaped CRC-16 frame builder: predicts the wire bytes
// of every accepted request and compares them with the response stream.
// Depends on ecfb_pkg, the channel interfaces in ecfb_if and the RTL top level.
module tb_top
   import ecfb_pkg::*;
();

   localparam int          CLOCK_PERIOD  = 20;
   localparam int          RESET_CYCLES  = 6;
   localparam int          IDLE_PERCENT  = 28;
   localparam int          SETTLE_CYCLES = 100;
   localparam int          MAX_REPORTS   = 40;
   localparam int          PHASE_ITEMS   = 85;
   localparam int          TAIL_PAYLOADS = 8;
   localparam logic [15:0] LONG_LENGTH   = 16'd65531;

   // Indexes that decode to no register.
   localparam logic [7:0] REG_SPARE_LOW  = 8'd4;
   localparam logic [7:0] REG_SPARE_HIGH = 8'hFF;

   typedef struct packed {
      logic        kind;
      logic [7:0]  command_group;
      logic [7:0]  command_code;
      logic [7:0]  response_flag;
      logic [7:0]  option_first;
      logic [7:0]  option_second;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
   } frame_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_done;
   } wire_byte_type;

   typedef struct packed {
      logic [7:0]  index;
      logic [15:0] data;
   } reg_write_type;

   logic clock;
   logic reset;

   ecfb_req_if req_bus ();
   ecfb_rsp_if rsp_bus ();
   ecfb_csr_if csr_bus ();

   escaped_crc16_frame_builder uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frame_req_type queued_requests[$];
   reg_write_type pending_writes[$];
   wire_byte_type expected_wire[$];

   // Shadow of the block: header registers and frame progress.
   logic [15:0] hdr_dst;
   logic [15:0] hdr_src;
   logic [7:0]  hdr_device;
   logic [7:0]  hdr_version;
   logic [15:0] crc_running;
   logic [15:0] payload_left;
   logic        frame_busy;

   // Stimulus side view of frame progress, used to shape the request mix.
   bit          gen_open;
   int unsigned gen_left;
   int unsigned gen_useful;

   bit          steady;
   int unsigned fail_count;
   int unsigned bytes_checked;
   int unsigned requests_taken;
   int unsigned requests_dropped;
   int unsigned frames_closed;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // One step of CRC-16/ARC, least significant bit first.
   function automatic logic [15:0] arc_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ ARC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   task automatic push_wire(logic [7:0] b, logic last);
      wire_byte_type w;
      w.out_byte   = b;
      w.frame_done = last;
      expected_wire.push_back(w);
   endtask

   task automatic push_stuffed(logic [7:0] b);
      case (b)
         PREAMBLE_VALUE: begin push_wire(ESC_LEAD_A, 1'b0); push_wire(ESC_TWO, 1'b0); end
         ESC_LEAD_A: begin push_wire(ESC_LEAD_A, 1'b0); push_wire(ESC_ONE, 1'b0); end
         END_VALUE: begin push_wire(ESC_LEAD_B, 1'b0); push_wire(ESC_TWO, 1'b0); end
         ESC_LEAD_B: begin push_wire(ESC_LEAD_B, 1'b0); push_wire(ESC_ONE, 1'b0); end
         default: push_wire(b, 1'b0);
      endcase
   endtask

   task automatic push_body(logic [7:0] b);
      crc_running = arc_next(crc_running, b);
      push_stuffed(b);
   endtask

   task automatic close_frame();
      push_stuffed(crc_running[7:0]);
      push_stuffed(crc_running[15:8]);
      push_wire(END_VALUE, 1'b1);
      frame_busy   = 1'b0;
      payload_left = '0;
      crc_running  = '0;
      frames_closed++;
   endtask

   // Works out the wire bytes that one accepted request gives.
   task automatic predict_frame_bytes(frame_req_type r);
      logic [15:0] flen;
      requests_taken++;
      if (r.kind == KIND_START) begin
         if (frame_busy) begin
            requests_dropped++;
            return;
         end
         flen         = r.payload_length + FRAME_LEN_BASE;
         frame_busy   = 1'b1;
         crc_running  = '0;
         payload_left = r.payload_length;
         for (int i = 0; i < PREAMBLE_BYTES; i++) push_wire(PREAMBLE_VALUE, 1'b0);
         push_body(hdr_dst[7:0]);
         push_body(hdr_dst[15:8]);
         push_body(hdr_src[7:0]);
         push_body(hdr_src[15:8]);
         for (int i = 0; i < 6; i++) push_body(8'h00);
         push_body(hdr_device);
         push_body(hdr_version);
         push_body(flen[7:0]);
         push_body(flen[15:8]);
         push_body(r.command_group);
         push_body(r.command_code);
         push_body(r.response_flag);
         push_body(r.option_first);
         push_body(r.option_second);
         if (payload_left == 0) close_frame();
      end else begin
         if (!frame_busy) begin
            requests_dropped++;
            return;
         end
         push_body(r.payload_byte);
         payload_left = payload_left - 16'd1;
         if (payload_left == 0) close_frame();
      end
   endtask

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] wanted);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch at wire byte %0d: %s got %02h, expected %02h",
                  bytes_checked, what, got, wanted);
   endtask

   // Request driver: presents queued requests, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (queued_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            frame_req_type r;
            r = queued_requests.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.kind           <= r.kind;
            req_bus.command_group  <= r.command_group;
            req_bus.command_code   <= r.command_code;
            req_bus.response_flag  <= r.response_flag;
            req_bus.option_first   <= r.option_first;
            req_bus.option_second  <= r.option_second;
            req_bus.payload_length <= r.payload_length;
            req_bus.payload_byte   <= r.payload_byte;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response receiver stalls at random.
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Register write driver.
   always @(posedge clock) begin
      if (reset) begin
         csr_bus.valid <= 1'b0;
      end else if (!csr_bus.valid || csr_bus.ready) begin
         if (pending_writes.size() != 0) begin
            reg_write_type w;
            w = pending_writes.pop_front();
            csr_bus.valid <= 1'b1;
            csr_bus.index <= w.index;
            csr_bus.data  <= w.data;
         end else begin
            csr_bus.valid <= 1'b0;
         end
      end
   end

   // Accepted register writes update the shadow header.
   always @(posedge clock) begin
      if (!reset && csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_DST_ADDRESS: hdr_dst = csr_bus.data;
            CSR_SRC_ADDRESS: hdr_src = csr_bus.data;
            CSR_DEVICE_TYPE: hdr_device = csr_bus.data[7:0];
            CSR_PROTOCOL_VERSION: hdr_version = csr_bus.data[7:0];
            default: ;
         endcase
      end
   end

   // Accepted requests feed the predictor.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         frame_req_type r;
         r.kind           = req_bus.kind;
         r.command_group  = req_bus.command_group;
         r.command_code   = req_bus.command_code;
         r.response_flag  = req_bus.response_flag;
         r.option_first   = req_bus.option_first;
         r.option_second  = req_bus.option_second;
         r.payload_length = req_bus.payload_length;
         r.payload_byte   = req_bus.payload_byte;
         predict_frame_bytes(r);
      end
   end

   // Accepted wire bytes are checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_wire.size() == 0) begin
            report_mismatch("unexpected byte", rsp_bus.out_byte, 8'h00);
         end else begin
            wire_byte_type w;
            w = expected_wire.pop_front();
            if (rsp_bus.out_byte !== w.out_byte)
               report_mismatch("out_byte", rsp_bus.out_byte, w.out_byte);
            if (rsp_bus.frame_done !== w.frame_done)
               report_mismatch("frame_done", {7'd0, rsp_bus.frame_done},
                               {7'd0, w.frame_done});
         end
         bytes_checked++;
      end
   end

   // Biased towards the four bytes that need stuffing.
   function automatic logic [7:0] pick_byte();
      logic [7:0] specials [4];
      specials = '{PREAMBLE_VALUE, ESC_LEAD_A, END_VALUE, ESC_LEAD_B};
      if ($urandom_range(99) < 25) return specials[2'($urandom_range(3))];
      return 8'($urandom_range(255));
   endfunction

   task automatic add_start(logic [15:0] plen, logic [7:0] g, logic [7:0] c, logic [7:0] f,
                            logic [7:0] o1, logic [7:0] o2);
      frame_req_type r;
      r.kind           = KIND_START;
      r.command_group  = g;
      r.command_code   = c;
      r.response_flag  = f;
      r.option_first   = o1;
      r.option_second  = o2;
      r.payload_length = plen;
      r.payload_byte   = 8'($urandom_range(255));
      queued_requests.push_back(r);
      if (!gen_open) begin
         gen_useful++;
         gen_left = {16'd0, plen};
         gen_open = (plen != 0);
      end
   endtask

   task automatic add_payload(logic [7:0] b);
      frame_req_type r;
      r.kind           = KIND_PAYLOAD;
      r.command_group  = 8'($urandom_range(255));
      r.command_code   = 8'($urandom_range(255));
      r.response_flag  = 8'($urandom_range(255));
      r.option_first   = 8'($urandom_range(255));
      r.option_second  = 8'($urandom_range(255));
      r.payload_length = 16'($urandom_range(65535));
      r.payload_byte   = b;
      queued_requests.push_back(r);
      if (gen_open) begin
         gen_useful++;
         gen_left--;
         if (gen_left == 0) gen_open = 0;
      end
   endtask

   // Mostly whole frames with short payloads, with stray requests mixed in.
   // Every frame is closed before the task returns.
   task automatic add_random_frames(int unsigned count);
      int unsigned first;
      int unsigned plen;
      first = gen_useful;
      while (gen_useful - first < count || gen_open) begin
         if (gen_open) begin
            if ($urandom_range(99) < 6)
               add_start(16'($urandom_range(65535)), pick_byte(), pick_byte(), pick_byte(),
                         pick_byte(), pick_byte());
            else
               add_payload(pick_byte());
         end else if ($urandom_range(99) < 8) begin
            add_payload(pick_byte());
         end else begin
            plen = ($urandom_range(99) < 10) ? $urandom_range(40, 12) : $urandom_range(6, 0);
            add_start(16'(plen), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                      pick_byte());
         end
      end
   endtask

   task automatic write_reg(logic [7:0] index, logic [15:0] data);
      reg_write_type w;
      w.index = index;
      w.data  = data;
      pending_writes.push_back(w);
   endtask

   task automatic write_header(logic [15:0] dst, logic [15:0] src, logic [15:0] dev,
                               logic [15:0] ver);
      write_reg(CSR_DST_ADDRESS, dst);
      write_reg(CSR_SRC_ADDRESS, src);
      write_reg(CSR_DEVICE_TYPE, dev);
      write_reg(CSR_PROTOCOL_VERSION, ver);
      do @(posedge clock); while (pending_writes.size() != 0 || csr_bus.valid);
   endtask

   // Waits until every request has gone in and every predicted byte has come out.
   task automatic wait_drained();
      do @(posedge clock);
      while (queued_requests.size() != 0 || req_bus.valid || expected_wire.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.kind           = KIND_START;
      req_bus.command_group  = '0;
      req_bus.command_code   = '0;
      req_bus.response_flag  = '0;
      req_bus.option_first   = '0;
      req_bus.option_second  = '0;
      req_bus.payload_length = '0;
      req_bus.payload_byte   = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = '0;
      csr_bus.data           = '0;
      hdr_dst      = 16'h0001;
      hdr_src      = 16'h8000;
      hdr_device   = 8'hFE;
      hdr_version  = 8'h02;
      crc_running  = '0;
      payload_left = '0;
      frame_busy   = 1'b0;
      steady       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset header: stray payload, empty frames,
      // stuffed command bytes and payload, and a start inside an open frame.
      add_payload(8'hFF);
      add_start(16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      add_start(16'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_start(16'd6, PREAMBLE_VALUE, ESC_LEAD_A, END_VALUE, ESC_LEAD_B, ESC_ONE);
      add_payload(PREAMBLE_VALUE);
      add_payload(ESC_LEAD_A);
      add_payload(END_VALUE);
      add_start(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_payload(ESC_LEAD_B);
      add_payload(8'h00);
      add_payload(8'hFF);
      add_payload(8'h5A);
      add_start(16'd1, 8'h12, 8'h34, ESC_ONE, 8'h00, 8'h00);
      add_payload(8'h12);
      add_start(16'd3, 8'hA5, 8'h5A, 8'h00, 8'hA6, 8'h5B);
      add_payload(8'h00);
      add_payload(8'hA5);
      add_payload(8'h5B);
      wait_drained();

      // Lowest header values, plus writes to indexes that hold no register.
      write_reg(REG_SPARE_LOW, 16'hFFFF);
      write_reg(REG_SPARE_HIGH, 16'h1234);
      write_header(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_random_frames(PHASE_ITEMS);
      wait_drained();

      // Highest header values; this phase runs with no gaps on either side.
      write_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      steady = 1;
      add_random_frames(PHASE_ITEMS);
      wait_drained();
      steady = 0;

      // Header bytes that themselves need stuffing.
      write_header(16'hA5A6, 16'h5A5B, 16'h00A5, 16'h005A);
      add_random_frames(PHASE_ITEMS);
      wait_drained();

      write_header(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)));
      add_random_frames(PHASE_ITEMS);
      wait_drained();

      // One oversized frame whose header length wraps round to zero; it is
      // given a few payload bytes and left open at the end of the run.
      add_start(LONG_LENGTH, pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
      repeat (TAIL_PAYLOADS) add_payload(pick_byte());
      wait_drained();

      $display("covered %0d requests (%0d dropped as out of order), %0d frames closed",
               requests_taken, requests_dropped, frames_closed);
      $display("checked %0d wire bytes over five header settings", bytes_checked);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Generous cap on the run.
   initial begin
      #4_000_000;
      $display("timeout with %0d wire bytes still expected", expected_wire.size());
      $display("simulation failed");
      $finish;
   end

endmodule
